/* sv/skc_pkg.sv */
// Shared types, constants and table functions for the stereo compressor.
`default_nettype none

package skc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LOG_DEPTH_DEF   = 256;
  localparam int DB_PER_LOG2     = 394566;
  localparam int LOG2_PER_DB     = 10885;
  localparam int SILENCE_DB      = -30720;
  localparam int RED_MAX         = 32767;
  localparam int ROOT_STEPS      = 16;
  localparam int DIV_STEPS       = 14;
  localparam int CFG_AW          = 5;

  localparam logic [15:0] RST_THRESHOLD = 16'hEC00;
  localparam logic [16:0] RST_INV_RATIO = 17'd32768;
  localparam logic [13:0] RST_KNEE      = 14'd0;
  localparam logic [15:0] RST_ATTACK    = 16'd64880;
  localparam logic [15:0] RST_RELEASE   = 16'd65470;
  localparam logic [15:0] RST_MAKEUP    = 16'd0;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_INV_RATIO = 3'd1,
    REG_KNEE      = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_MAKEUP    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic [16:0]        inv_ratio;
    logic [13:0]        knee_width_db;
    logic [15:0]        attack_coeff;
    logic [15:0]        release_coeff;
    logic signed [15:0] makeup_gain_db;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CAPTURE, OP_MONO, OP_NORM, OP_LOG, OP_DB, OP_CURVE, OP_KMUL,
    OP_DIV, OP_BAL, OP_EXP, OP_ROOT, OP_MULL, OP_MULR, OP_FIN, OP_LOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic silent;
    logic normed;
    logic hard;
    logic knee;
  } status_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // Q2.30 value of 2^(2^-k).
  function automatic logic [31:0] root_val(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 1; j <= ROOT_STEPS; j++) begin
      if (j <= k) r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

  // Q0.16 log2 of the mantissa 1 + i/2^lb; the depth is a power of two.
  function automatic logic [15:0] log_val(input int i, input int lb);
    logic [63:0] x;
    logic [15:0] acc;
    x   = (64'd1 << 30) + ((64'(i) << 30) >> lb);
    acc = '0;
    for (int k = 1; k <= 16; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        acc[16-k] = 1'b1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* sv/skc_regs.sv */
// Configuration register file behind the APB-style port.
`default_nettype none

module skc_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output skc_pkg::cfg_t                   cfg
);
  import skc_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db   <= RST_THRESHOLD;
      cfg.inv_ratio      <= RST_INV_RATIO;
      cfg.knee_width_db  <= RST_KNEE;
      cfg.attack_coeff   <= RST_ATTACK;
      cfg.release_coeff  <= RST_RELEASE;
      cfg.makeup_gain_db <= RST_MAKEUP;
    end else if (wr) begin
      unique case (idx)
        REG_THRESHOLD: cfg.threshold_db   <= pwdata[15:0];
        REG_INV_RATIO: cfg.inv_ratio      <= pwdata[16:0];
        REG_KNEE:      cfg.knee_width_db  <= pwdata[13:0];
        REG_ATTACK:    cfg.attack_coeff   <= pwdata[15:0];
        REG_RELEASE:   cfg.release_coeff  <= pwdata[15:0];
        REG_MAKEUP:    cfg.makeup_gain_db <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = {16'h0, cfg.threshold_db};
      REG_INV_RATIO: prdata = {15'h0, cfg.inv_ratio};
      REG_KNEE:      prdata = {18'h0, cfg.knee_width_db};
      REG_ATTACK:    prdata = {16'h0, cfg.attack_coeff};
      REG_RELEASE:   prdata = {16'h0, cfg.release_coeff};
      REG_MAKEUP:    prdata = {16'h0, cfg.makeup_gain_db};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/skc_ctrl.sv */
// Sequencing state machine for the compressor datapath.
`default_nettype none

module skc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire skc_pkg::status_t status,
  output skc_pkg::cmd_t         cmd
);
  import skc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MONO, S_NORM, S_LOG, S_DB, S_CURVE, S_KMUL, S_DIV,
    S_BAL, S_EXP, S_ROOT, S_MULL, S_MULR, S_FIN, S_OUT
  } state_t;

  state_t     state;
  logic [3:0] cnt;
  logic       free;

  assign free     = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.step = cnt;
    unique case (state)
      S_IDLE:  cmd.op = s_tvalid ? OP_CAPTURE : OP_IDLE;
      S_MONO:  cmd.op = OP_MONO;
      S_NORM:  cmd.op = (status.silent || status.normed) ? OP_IDLE : OP_NORM;
      S_LOG:   cmd.op = OP_LOG;
      S_DB:    cmd.op = OP_DB;
      S_CURVE: cmd.op = OP_CURVE;
      S_KMUL:  cmd.op = OP_KMUL;
      S_DIV:   cmd.op = OP_DIV;
      S_BAL:   cmd.op = OP_BAL;
      S_EXP:   cmd.op = OP_EXP;
      S_ROOT:  cmd.op = OP_ROOT;
      S_MULL:  cmd.op = OP_MULL;
      S_MULR:  cmd.op = OP_MULR;
      S_FIN:   cmd.op = OP_FIN;
      S_OUT:   cmd.op = free ? OP_LOAD : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (s_tvalid) state <= S_MONO;
        S_MONO:  state <= status.bypass ? S_EXP : S_NORM;
        S_NORM: begin
          if (status.silent) state <= S_CURVE;
          else if (status.normed) state <= S_LOG;
        end
        S_LOG:   state <= S_DB;
        S_DB:    state <= S_CURVE;
        S_CURVE: state <= status.knee ? S_KMUL : S_BAL;
        S_KMUL: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          if (cnt == 4'(DIV_STEPS - 1)) state <= S_BAL;
          cnt <= cnt + 4'd1;
        end
        S_BAL:   state <= S_EXP;
        S_EXP: begin
          state <= S_ROOT;
          cnt   <= '0;
        end
        S_ROOT: begin
          if (cnt == 4'(ROOT_STEPS - 1)) state <= S_MULL;
          cnt <= cnt + 4'd1;
        end
        S_MULL:  state <= S_MULR;
        S_MULR:  state <= S_FIN;
        S_FIN:   state <= S_OUT;
        S_OUT:   if (free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/skc_dp.sv */
// Datapath: level detection, knee curve, ballistics, gain and output scaling.
`default_nettype none

module skc_dp #(
  parameter int SAMPLE_BITS     = skc_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = skc_pkg::LOG_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire skc_pkg::cfg_t          cfg,
  input  wire skc_pkg::cmd_t          cmd,
  output skc_pkg::status_t            status,
  input  wire logic [SAMPLE_BITS-1:0] left_sample,
  input  wire logic [SAMPLE_BITS-1:0] right_sample,
  output logic [SAMPLE_BITS-1:0]      left_out,
  output logic [SAMPLE_BITS-1:0]      right_out,
  output logic [14:0]                 gain_reduction_db
);
  import skc_pkg::*;

  localparam int SW  = SAMPLE_BITS;
  localparam int LB  = $clog2(LOG_TABLE_DEPTH);
  localparam int SHW = $clog2(SW);
  localparam int PW  = SW + 32;
  localparam logic [SW-1:0] SIL =
    SW'(((64'd1 << (SW - 1)) + 64'd999999) / 64'd1000000);
  localparam logic [64:0] HALF_FS = 65'd1 << (SW - 1);

  logic [15:0] log_rom [LOG_TABLE_DEPTH];
  logic [31:0] root_rom [ROOT_STEPS];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_log
    assign log_rom[g] = log_val(g, LB);
  end
  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    assign root_rom[g] = root_val(g + 1);
  end

  logic signed [SW-1:0] left_r, right_r;
  logic [SW-1:0]        n_r;
  logic [SHW-1:0]       s_r;
  logic [20:0]          l2mag_r;
  logic                 l2neg_r;
  logic signed [17:0]   x_r;
  logic [14:0]          red_r;
  logic [29:0]          uu_r;
  logic [13:0]          rem_r, q_r;
  logic [14:0]          smoothed_reduction, gr_r;
  logic signed [16:0]   gdb_r;
  logic [6:0]           sh_r;
  logic                 zero_r;
  logic [15:0]          frac_r;
  logic [31:0]          m_r;
  logic [PW-1:0]        p_r;
  logic [SW-1:0]        resl_r, resr_r;

  logic signed [SW:0]   sum;
  logic [SW-1:0]        mono, amono, magl, magr, mag;
  logic [15:0]          rom_val;
  logic [40:0]          dbp;
  logic [16:0]          xm;
  logic signed [18:0]   d;
  logic signed [19:0]   d2, wide, u;
  logic [19:0]          ad2;
  logic                 hard, in_knee;
  logic [16:0]          ratio, slope;
  logic [32:0]          hp;
  logic [14:0]          hred;
  logic [46:0]          num;
  logic [14:0]          t;
  logic                 ge;
  logic [13:0]          q_next;
  logic [15:0]          alpha;
  logic signed [15:0]   diff;
  logic signed [32:0]   bp;
  logic signed [33:0]   total;
  logic [17:0]          grsum;
  logic [14:0]          gr_new;
  logic signed [33:0]   ep;
  logic signed [22:0]   e16;
  logic signed [8:0]    shs;
  logic [63:0]          rp;
  logic [64:0]          rnd, rs, lim, rv;
  logic                 neg;
  logic [SW-1:0]        res;

  assign sum   = (SW+1)'(left_r) + (SW+1)'(right_r);
  assign mono  = sum[SW:1];
  assign amono = mono[SW-1] ? -mono : mono;
  assign magl  = left_r[SW-1] ? -left_r : left_r;
  assign magr  = right_r[SW-1] ? -right_r : right_r;
  assign mag   = (cmd.op == OP_MULL) ? magl : magr;

  assign rom_val = log_rom[n_r[SW-2 -: LB]];
  assign dbp     = 41'(l2mag_r) * 41'(DB_PER_LOG2) + (41'd1 << 23);
  assign xm      = dbp[40:24];

  assign d       = 19'(x_r) - 19'(cfg.threshold_db);
  assign d2      = {d, 1'b0};
  assign wide    = $signed({6'd0, cfg.knee_width_db});
  assign ad2     = d2[19] ? 20'(-d2) : 20'(d2);
  assign hard    = d2 >= wide;
  assign in_knee = !hard && (cfg.knee_width_db != '0) &&
                   (ad2 <= {6'd0, cfg.knee_width_db});
  assign u     = d2 + wide;
  assign ratio = cfg.inv_ratio[16] ? 17'h10000 : cfg.inv_ratio;
  assign slope = 17'h10000 - ratio;
  assign hp    = {17'd0, d[15:0]} * {16'd0, slope};
  assign hred  = (hp[32:16] > 17'(RED_MAX)) ? 15'(RED_MAX) : hp[14+16:16];
  assign num   = 47'(uu_r) * 47'(slope);

  assign t      = {rem_r, q_r[13]};
  assign ge     = t >= {1'b0, cfg.knee_width_db};
  assign q_next = {q_r[12:0], ge};

  assign alpha  = (red_r > smoothed_reduction) ? cfg.attack_coeff : cfg.release_coeff;
  assign diff   = $signed({1'b0, smoothed_reduction}) - $signed({1'b0, red_r});
  assign bp     = $signed({1'b0, alpha}) * diff;
  assign total  = $signed({3'd0, red_r, 16'd0}) + 34'(bp) + 34'sd32768;
  assign grsum  = total[33:16];
  assign gr_new = (grsum > 18'(RED_MAX)) ? 15'(RED_MAX) : grsum[14:0];

  assign ep  = 34'(gdb_r) * 34'sd10885;
  assign e16 = ep[30:8];
  assign shs = 9'sd30 - 9'($signed(e16[22:16]));
  assign rp  = 64'(m_r) * 64'(root_rom[cmd.step]);

  // The gain exponent never exceeds 21, so the product is only ever shifted right.
  assign rnd = 65'(p_r) + (65'd1 << (sh_r - 7'd1));
  assign rs  = rnd >> sh_r;
  assign neg = (cmd.op == OP_MULR) ? left_r[SW-1] : right_r[SW-1];
  assign lim = neg ? HALF_FS : HALF_FS - 65'd1;
  assign rv  = zero_r ? 65'd0 : ((rs > lim) ? lim : rs);
  assign res = neg ? -rv[SW-1:0] : rv[SW-1:0];

  assign status.bypass = !cfg.threshold_db[15];
  assign status.silent = n_r < SIL;
  assign status.normed = n_r[SW-1];
  assign status.hard   = hard;
  assign status.knee   = in_knee;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_reduction <= '0;
    end else if (cmd.op == OP_BAL) begin
      smoothed_reduction <= gr_new;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        left_r  <= left_sample;
        right_r <= right_sample;
      end
      OP_MONO: begin
        n_r   <= amono;
        s_r   <= '0;
        x_r   <= 18'(SILENCE_DB);
        gdb_r <= 17'(cfg.makeup_gain_db);
        gr_r  <= '0;
      end
      OP_NORM: begin
        n_r <= n_r << 1;
        s_r <= s_r + 1'b1;
      end
      OP_LOG: begin
        if (s_r == '0) begin
          l2mag_r <= 21'(rom_val);
          l2neg_r <= 1'b0;
        end else begin
          l2mag_r <= 21'({s_r, 16'h0}) - 21'(rom_val);
          l2neg_r <= 1'b1;
        end
      end
      OP_DB:   x_r <= l2neg_r ? -$signed({1'b0, xm}) : $signed({1'b0, xm});
      OP_CURVE: begin
        red_r <= hard ? hred : '0;
        uu_r  <= u[14:0] * u[14:0];
      end
      OP_KMUL: begin
        rem_r <= num[46:33];
        q_r   <= num[32:19];
      end
      OP_DIV: begin
        rem_r <= ge ? 14'(t - {1'b0, cfg.knee_width_db}) : t[13:0];
        q_r   <= q_next;
        red_r <= {1'b0, q_next};
      end
      OP_BAL: begin
        gr_r  <= gr_new;
        gdb_r <= 17'(cfg.makeup_gain_db) - $signed({2'b0, gr_new});
      end
      OP_EXP: begin
        frac_r <= e16[15:0];
        sh_r   <= shs[6:0];
        zero_r <= shs >= 9'sd63;
        m_r    <= 32'd1 << 30;
      end
      OP_ROOT: if (frac_r[~cmd.step]) m_r <= rp[61:30];
      OP_MULL: p_r <= {32'd0, mag} * {{SW{1'b0}}, m_r};
      OP_MULR: begin
        resl_r <= res;
        p_r    <= {32'd0, mag} * {{SW{1'b0}}, m_r};
      end
      OP_FIN:  resr_r <= res;
      OP_LOAD: begin
        left_out          <= resl_r;
        right_out         <= resr_r;
        gain_reduction_db <= gr_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/soft_knee_stereo_compressor_top.sv */
// Top level of the soft-knee stereo compressor.
//
//   Channel  Direction  Fields
//   s_*      in         left_sample, right_sample
//   m_*      out        left_out, right_out, gain_reduction_db
//   APB      in/out     six configuration registers at 4*i
//
// With threshold at or above 0 dB a stereo pair skips level detection and
// the knee curve; otherwise its run time varies with the bit-per-cycle level
// normalizer (up to 20 shifts at the default sample width), the knee divider
// and the 16-step gain exponent.
// Reset is synchronous; the next pair is taken while a result waits on m_*.
// A stalled output holds the following finished pair in the datapath.
`default_nettype none

module soft_knee_stereo_compressor_top #(
  parameter int SAMPLE_BITS     = skc_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_TABLE_DEPTH = skc_pkg::LOG_DEPTH_DEF,
  parameter int IN_W            = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W           = ((2 * SAMPLE_BITS + 15 + 7) / 8) * 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [IN_W-1:0]            s_tdata,  // left_sample, right_sample
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // left_out, right_out, gain_reduction_db
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import skc_pkg::*;

  cfg_t                   cfg;
  cmd_t                   cmd;
  status_t                status;
  logic [SAMPLE_BITS-1:0] left_out, right_out;
  logic [14:0]            gain_reduction_db;

  skc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  skc_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .status, .cmd
  );

  skc_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_dp (
    .clk, .rst, .cfg, .cmd, .status,
    .left_sample(s_tdata[SAMPLE_BITS-1:0]),
    .right_sample(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .left_out, .right_out, .gain_reduction_db
  );

  assign m_tdata = OUT_W'({gain_reduction_db, right_out, left_out});

endmodule

`default_nettype wire

/* sv/skc_checker.sv */
// Port-level checks for the compressor top level and their bind.
`default_nettype none

module skc_checker #(
  parameter int DATA_W = 64
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a pair is in work");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind soft_knee_stereo_compressor_top skc_checker #(.DATA_W(OUT_W)) u_skc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

/* test/soft_knee_stereo_compressor_top_tb.sv */
// Self-checking testbench for the soft-knee stereo compressor top level.
`timescale 1ns / 100ps
`default_nettype none

module soft_knee_stereo_compressor_top_tb;
  import skc_pkg::*;

  localparam int SB = 24;
  localparam int IN_W = 48;
  localparam int OUT_W = 64;
  localparam int STALL_LIMIT = 20000;
  localparam longint FULL_MAG = 64'd1 << (SB - 1);
  localparam longint SILENCE_MAG = (FULL_MAG + 999999) / 1000000;

  typedef struct packed {
    logic signed [23:0] left_s;
    logic signed [23:0] right_s;
  } pair_t;

  typedef struct packed {
    logic [14:0] red_o;
    logic signed [23:0] right_o;
    logic signed [23:0] left_o;
  } gained_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  soft_knee_stereo_compressor_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] log2_mant [LOG_DEPTH_DEF];
  logic [63:0] exp_root [17];
  cfg_t settings;
  logic [15:0] held_reduction;

  pair_t pending_pairs[$];
  gained_t gained_expect[$];
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int failures = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mono_level_db(longint a);
    int p;
    longint idx;
    longint l2;
    if (a < SILENCE_MAG) return SILENCE_DB;
    p = 0;
    while ((a >> (p + 1)) != 0) p++;
    idx = ((a - (longint'(1) << p)) * LOG_DEPTH_DEF) >> p;
    if (idx >= LOG_DEPTH_DEF) idx = LOG_DEPTH_DEF - 1;
    l2 = longint'(p - (SB - 1)) * 65536 + longint'(log2_mant[idx]);
    if (l2 >= 0) return (l2 * DB_PER_LOG2 + (longint'(1) << 23)) >>> 24;
    return -((-l2 * DB_PER_LOG2 + (longint'(1) << 23)) >>> 24);
  endfunction

  function automatic logic [23:0] apply_gain(longint s, longint ip, logic [63:0] m);
    logic [63:0] lim;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    longint sh;
    longint ls;
    lim = s < 0 ? FULL_MAG : FULL_MAG - 1;
    mag = s < 0 ? -s : s;
    prod = mag * m;
    sh = 30 - ip;
    if (prod == 0) return '0;
    if (sh > 0) begin
      r = sh >= 63 ? 0 : (prod + (64'd1 << (sh - 1))) >> sh;
    end else begin
      ls = -sh;
      if (ls >= 32 || prod > (lim >> ls)) r = lim;
      else r = prod << ls;
    end
    if (r > lim) r = lim;
    return s < 0 ? 24'(-longint'(r)) : 24'(r);
  endfunction

  function automatic gained_t compress_pair(pair_t in_pair);
    gained_t res;
    longint left;
    longint right;
    longint mono;
    longint thr;
    longint mk;
    longint g_db;
    longint e16;
    longint ip;
    longint frac;
    longint a;
    longint d;
    longint w;
    longint ad;
    logic [63:0] m;
    logic [63:0] gr;
    logic [63:0] r;
    logic [63:0] slope;
    logic [63:0] red;
    logic [63:0] prev;
    logic [63:0] alpha;
    logic [63:0] u;
    left = in_pair.left_s;
    right = in_pair.right_s;
    mono = shr_floor(left + right, 1);
    thr = settings.threshold_db;
    mk = settings.makeup_gain_db;
    m = 64'd1 << 30;
    gr = 0;
    if (thr >= 0) begin
      g_db = mk;
    end else begin
      a = mono < 0 ? -mono : mono;
      d = mono_level_db(a) - thr;
      w = settings.knee_width_db;
      r = settings.inv_ratio > 65536 ? 65536 : settings.inv_ratio;
      slope = 65536 - r;
      red = 0;
      ad = d < 0 ? -d : d;
      if (2 * d >= w) begin
        red = (d * slope) >> 16;
      end else if (w > 0 && 2 * ad <= w) begin
        u = 2 * d + w;
        red = (slope * u * u) / (w * 8 * 65536);
      end
      if (red > RED_MAX) red = RED_MAX;
      prev = held_reduction;
      alpha = red > prev ? settings.attack_coeff : settings.release_coeff;
      gr = (alpha * prev + (65536 - alpha) * red + 32768) >> 16;
      if (gr > RED_MAX) gr = RED_MAX;
      held_reduction = gr[15:0];
      g_db = mk - longint'(gr);
    end
    e16 = shr_floor(g_db * LOG2_PER_DB, 8);
    ip = shr_floor(e16, 16);
    frac = e16 - ip * 65536;
    for (int k = 1; k <= 16; k++)
      if ((frac >> (16 - k)) & 1) m = (m * exp_root[k]) >> 30;
    res.left_o = apply_gain(left, ip, m);
    res.right_o = apply_gain(right, ip, m);
    res.red_o = gr[14:0];
    return res;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: settings.threshold_db = value[15:0];
      REG_INV_RATIO: settings.inv_ratio = value[16:0];
      REG_KNEE: settings.knee_width_db = value[13:0];
      REG_ATTACK: settings.attack_coeff = value[15:0];
      REG_RELEASE: settings.release_coeff = value[15:0];
      default: settings.makeup_gain_db = value[15:0];
    endcase
  endtask

  task automatic drain;
    while (pending_pairs.size() != 0 || gained_expect.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(0, 9);
    p.left_s = $urandom;
    p.right_s = $urandom;
    if (kind < 4) begin
      p.left_s = $signed(p.left_s) >>> $urandom_range(0, 23);
      p.right_s = (kind == 0) ? p.left_s : $signed(p.right_s) >>> $urandom_range(0, 23);
    end else if (kind == 4) begin
      p.right_s = -p.left_s;
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pair_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) void'(pending_pairs.pop_front());
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_pairs[0];
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.right_s, nxt.left_s};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pair_t taken;
    if (!rst && s_tvalid && s_tready) begin
      taken.left_s = s_tdata[23:0];
      taken.right_s = s_tdata[47:24];
      gained_expect.push_back(compress_pair(taken));
    end
  end

  always @(posedge clk) begin
    gained_t got;
    gained_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(0, 99) >= receiver_stall_pct;
      if (m_tvalid && m_tready) begin
        got = m_tdata[62:0];
        if (gained_expect.size() == 0) begin
          $error("unexpected result beat %h", m_tdata);
          failures++;
        end else begin
          want = gained_expect.pop_front();
          if (got.left_o !== want.left_o) begin
            $error("left_out expected %0d got %0d", want.left_o, got.left_o);
            failures++;
          end
          if (got.right_o !== want.right_o) begin
            $error("right_out expected %0d got %0d", want.right_o, got.right_o);
            failures++;
          end
          if (got.red_o !== want.red_o) begin
            $error("gain_reduction_db expected %0d got %0d", want.red_o, got.red_o);
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    logic [31:0] thr_pick [6];
    logic [31:0] makeup_pick [6];
    logic [31:0] ratio_pick [6];
    logic [31:0] knee_pick [6];
    thr_pick = '{32'hFFFF8800, 32'hFFFFEC00, 32'd0, 32'hFFFFFFFF, 32'hFFFFD800, 32'h7FFF};
    makeup_pick = '{32'h7800, 32'hFFFF8800, 32'd0, 32'h0C00, 32'hFFFFFC00, 32'h0400};
    ratio_pick = '{32'd1, 32'd65536, 32'd16384, 32'd0, 32'd131071, 32'd4096};
    knee_pick = '{32'd12800, 32'd0, 32'd2560, 32'd16383, 32'd1, 32'd512};
    for (int i = 0; i < LOG_DEPTH_DEF; i++) begin
      logic [63:0] x;
      logic [15:0] acc;
      x = (64'd1 << 30) + ((64'(i) << 30) / LOG_DEPTH_DEF);
      acc = 0;
      for (int k = 1; k <= 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          acc[16-k] = 1'b1;
        end
      end
      log2_mant[i] = acc;
    end
    exp_root[0] = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) exp_root[k] = int_sqrt(exp_root[k-1] << 30);
    settings = '{RST_THRESHOLD, RST_INV_RATIO, RST_KNEE, RST_ATTACK, RST_RELEASE, RST_MAKEUP};
    held_reduction = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pending_pairs.push_back('{24'sh7FFFFF, 24'sh7FFFFF});
    pending_pairs.push_back('{24'sh800000, 24'sh800000});
    pending_pairs.push_back('{24'sh7FFFFF, 24'sh800000});
    pending_pairs.push_back('{24'sd0, 24'sd0});
    pending_pairs.push_back('{24'sd8, 24'sd8});
    pending_pairs.push_back('{24'sd9, 24'sd9});
    pending_pairs.push_back('{-24'sd1, 24'sd0});
    pending_pairs.push_back('{24'sh400000, 24'sh400000});
    drain();
    write_reg(REG_ATTACK, 0);
    write_reg(REG_RELEASE, 0);
    write_reg(REG_INV_RATIO, 0);
    write_reg(REG_THRESHOLD, 32'hFFFF8800);
    write_reg(REG_MAKEUP, 32'h7800);
    pending_pairs.push_back('{24'sh7FFFFF, 24'sh800000});
    pending_pairs.push_back('{24'sd100, -24'sd100});
    pending_pairs.push_back('{24'sh7FFFFF, 24'sh7FFFFF});
    drain();
    write_reg(REG_THRESHOLD, 0);
    pending_pairs.push_back('{24'sd1000, -24'sd5});
    pending_pairs.push_back('{24'sh800000, 24'sh7FFFFF});
    drain();
    write_reg(REG_KNEE, 12800);
    write_reg(REG_THRESHOLD, 32'hFFFFEC00);
    write_reg(REG_INV_RATIO, 131071);
    write_reg(REG_MAKEUP, 32'hFFFF8800);
    pending_pairs.push_back('{24'sh200000, 24'sh200000});
    pending_pairs.push_back('{24'sh7FFFFF, 24'sh7FFFFF});
    drain();

    for (phase = 0; phase < 6; phase++) begin
      write_reg(REG_THRESHOLD, thr_pick[phase]);
      write_reg(REG_INV_RATIO, ratio_pick[phase]);
      write_reg(REG_KNEE, knee_pick[phase]);
      write_reg(REG_ATTACK, (phase == 1) ? 32'd65535 : $urandom_range(0, 65535));
      write_reg(REG_RELEASE, (phase == 2) ? 32'd65535 : $urandom_range(0, 65535));
      write_reg(REG_MAKEUP, makeup_pick[phase]);
      case (phase % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      for (int i = 0; i < 125; i++) pending_pairs.push_back(rand_pair());
      drain();
    end

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
sv/skc_pkg.sv
sv/skc_regs.sv
sv/skc_ctrl.sv
sv/skc_dp.sv
sv/soft_knee_stereo_compressor_top.sv
sv/skc_checker.sv
test/soft_knee_stereo_compressor_top_tb.sv
